FILE: rtl/nrr_pkg.sv
// Shared constants and types for the Newton-Raphson reciprocal unit.
`timescale 1ns / 1ps
`default_nettype none

package nrr_pkg;

  // Data widths: one machine word and a full double-word product.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned PROD_W = 2 * WORD_W;

  // Default configuration of the unit.
  localparam int unsigned ITERATIONS_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF  = 60;

  // Cycles taken by one refinement step.
  localparam int unsigned STEP_LAT = 6;

  // 1.0 in Q1.63 and its right-shift for the correction product.
  localparam logic [WORD_W-1:0] ONE_Q63   = 64'h8000_0000_0000_0000;
  localparam int unsigned       Q63_SHIFT = 63;

  // Seeds in Q1.63, rounded to nearest.
  localparam logic [WORD_W-1:0] SEED_HALF = 64'h4000_0000_0000_0000;
  localparam logic [WORD_W-1:0] SEED_03   = 64'd2767011611056432742;
  localparam logic [WORD_W-1:0] SEED_02   = 64'd1844674407370955162;
  localparam logic [WORD_W-1:0] SEED_01   = 64'd922337203685477581;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage : nrr_pkg

`default_nettype wire

FILE: rtl/nrr_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none

module nrr_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire nrr_pkg::word_t a_i,
  input  wire nrr_pkg::word_t b_i,
  output nrr_pkg::prod_t     prod_o
);

  localparam int unsigned H = nrr_pkg::HALF_W;
  localparam int unsigned W = nrr_pkg::WORD_W;
  localparam int unsigned P = nrr_pkg::PROD_W;

  logic [W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [P-1:0] prod_d, prod_q;

  // First stage: the four partial products, each registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= W'(a_i[H-1:0]) * W'(b_i[H-1:0]);
      p01_q <= W'(a_i[H-1:0]) * W'(b_i[W-1:H]);
      p10_q <= W'(a_i[W-1:H]) * W'(b_i[H-1:0]);
      p11_q <= W'(a_i[W-1:H]) * W'(b_i[W-1:H]);
    end
  end

  // Second stage: align and add the partial products.
  always_comb begin
    prod_d = {p11_q, p00_q}
           + (P'(p01_q) << H)
           + (P'(p10_q) << H);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

  // The reset has no effect on the datapath; tie it into nothing but the port list.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule : nrr_mul

`default_nettype wire

FILE: rtl/nrr_seed.sv
// Seed selection stage: picks the starting estimate from four segments of x.
`timescale 1ns / 1ps
`default_nettype none

module nrr_seed #(
  parameter int unsigned FRAC_BITS = nrr_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire nrr_pkg::word_t x_i,
  output logic                valid_o,
  output nrr_pkg::word_t      x_o,
  output nrr_pkg::word_t      r_o
);

  localparam int unsigned W = nrr_pkg::WORD_W;

  // Segment bounds in the format of x; 3.3 is rounded to nearest.
  localparam logic [W-1:0] TWO_X  = W'(2) << FRAC_BITS;
  localparam logic [W-1:0] FIVE_X = W'(5) << FRAC_BITS;
  localparam logic [W-1:0] UNIT3  = W'(3) << FRAC_BITS;
  localparam logic [W-1:0] THR33  = UNIT3 + (UNIT3 + W'(5)) / W'(10);

  logic         valid_q;
  logic [W-1:0] x_q, r_q, r_d;

  // Seed lookup by segment.
  always_comb begin
    priority if (x_i <= TWO_X) begin
      r_d = nrr_pkg::SEED_HALF;
    end else if (x_i < THR33) begin
      r_d = nrr_pkg::SEED_03;
    end else if (x_i <= FIVE_X) begin
      r_d = nrr_pkg::SEED_02;
    end else begin
      r_d = nrr_pkg::SEED_01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_i;
      r_q <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign r_o     = r_q;

endmodule : nrr_seed

`default_nettype wire

FILE: rtl/nrr_step.sv
// One Newton-Raphson refinement step r = r + (1 - r*x)*r as a six-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

module nrr_step #(
  parameter int unsigned FRAC_BITS = nrr_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire nrr_pkg::word_t x_i,
  input  wire nrr_pkg::word_t r_i,
  output logic                valid_o,
  output nrr_pkg::word_t      x_o,
  output nrr_pkg::word_t      r_o
);

  localparam int unsigned W = nrr_pkg::WORD_W;
  localparam int unsigned P = nrr_pkg::PROD_W;
  localparam int unsigned S = nrr_pkg::Q63_SHIFT;

  // Valid bits for the six stages.
  logic [nrr_pkg::STEP_LAT-1:0] v_q;

  // Side-band registers that travel beside the multipliers.
  logic [W-1:0] s1_r_q, s1_x_q, s2_r_q, s2_x_q;
  logic [W-1:0] s3_r_q, s3_x_q, s3_d_q;
  logic         s3_neg_q, s4_neg_q, s5_neg_q;
  logic [W-1:0] s4_r_q, s4_x_q, s5_r_q, s5_x_q;
  logic [W-1:0] s6_r_q, s6_x_q;

  logic [P-1:0] prod_rx, prod_dr;

  // Stage 3 signals: scaled product and the size of the error term.
  logic [P-1:0] rx_shift;
  logic [W-1:0] p_sat, s3_d_d;
  logic         s3_neg_d;

  // Stage 6 signals: correction and update.
  logic [P-1:0] dr_shift;
  logic [W-1:0] corr, corr_up, r_new, s6_r_d;
  logic [W:0]   sum_pos;
  logic         inexact;

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[nrr_pkg::STEP_LAT-2:0], valid_i};
    end
  end

  // Stages 1 and 2: the product r*x.
  nrr_mul u_mul_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .a_i    (r_i),
    .b_i    (x_i),
    .prod_o (prod_rx)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_r_q <= r_i;
      s1_x_q <= x_i;
      s2_r_q <= s1_r_q;
      s2_x_q <= s1_x_q;
    end
  end

  // Stage 3: scale, saturate, and form |1 - r*x| with its sign.
  always_comb begin
    rx_shift = prod_rx >> FRAC_BITS;
    p_sat    = (|rx_shift[P-1:W]) ? '1 : rx_shift[W-1:0];
    s3_neg_d = p_sat > nrr_pkg::ONE_Q63;
    s3_d_d   = s3_neg_d ? (p_sat - nrr_pkg::ONE_Q63) : (nrr_pkg::ONE_Q63 - p_sat);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_r_q   <= s2_r_q;
      s3_x_q   <= s2_x_q;
      s3_d_q   <= s3_d_d;
      s3_neg_q <= s3_neg_d;
    end
  end

  // Stages 4 and 5: the product |1 - r*x| * r.
  nrr_mul u_mul_dr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .a_i    (s3_d_q),
    .b_i    (s3_r_q),
    .prod_o (prod_dr)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_r_q   <= s3_r_q;
      s4_x_q   <= s3_x_q;
      s4_neg_q <= s3_neg_q;
      s5_r_q   <= s4_r_q;
      s5_x_q   <= s4_x_q;
      s5_neg_q <= s4_neg_q;
    end
  end

  // Stage 6: apply the correction, rounding a negative one up in magnitude.
  always_comb begin
    dr_shift = prod_dr >> S;
    corr     = (|dr_shift[P-1:W]) ? '1 : dr_shift[W-1:0];
    inexact  = |prod_dr[S-1:0];
    corr_up  = corr + W'(inexact && (corr != '1));
    sum_pos  = {1'b0, s5_r_q} + {1'b0, corr};
    if (s5_neg_q) begin
      r_new = (corr_up >= s5_r_q) ? '0 : (s5_r_q - corr_up);
    end else begin
      r_new = sum_pos[W] ? '1 : sum_pos[W-1:0];
    end
    s6_r_d = (r_new > nrr_pkg::ONE_Q63) ? nrr_pkg::ONE_Q63 : r_new;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_r_q <= s6_r_d;
      s6_x_q <= s5_x_q;
    end
  end

  assign valid_o = v_q[nrr_pkg::STEP_LAT-1];
  assign x_o     = s6_x_q;
  assign r_o     = s6_r_q;

endmodule : nrr_step

`default_nettype wire

FILE: rtl/newton_raphson_reciprocal_unit.sv
// Top level of the pipelined Newton-Raphson reciprocal unit.
`timescale 1ns / 1ps
`default_nettype none

// Computes 1/x in unsigned Q1.63 for a divisor x in [1,10) given with FRAC_BITS
// fraction bits. A seed is taken from four segments of x and refined by
// ITERATIONS Newton-Raphson steps with truncated products; divisors below one
// saturate to 1.0. The unit takes one beat per cycle while the pipeline is not
// held, and each result passes one seed stage, then six stages per step,
// since each step holds two 64x64 multiplications that are each split over two
// stages. The whole pipeline holds while a result waits on recip_stall_i, and
// x_stall_o is raised for those cycles.
module newton_raphson_reciprocal_unit #(
  parameter int unsigned ITERATIONS = nrr_pkg::ITERATIONS_DEF,
  parameter int unsigned FRAC_BITS  = nrr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        x_valid_i,
  output logic                             x_stall_o,
  input  wire logic [nrr_pkg::WORD_W-1:0] x_value_i,
  output logic                             recip_valid_o,
  input  wire logic                        recip_stall_i,
  output logic      [nrr_pkg::WORD_W-1:0] recip_value_o
);

  logic pipe_en;

  logic           v_chain [ITERATIONS+1];
  nrr_pkg::word_t x_chain [ITERATIONS+1];
  nrr_pkg::word_t r_chain [ITERATIONS+1];

  // The pipeline advances unless a finished beat is held at the output.
  assign pipe_en   = !(recip_valid_o && recip_stall_i);
  assign x_stall_o = !pipe_en;

  // Seed stage.
  nrr_seed #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (x_valid_i),
    .x_i     (x_value_i),
    .valid_o (v_chain[0]),
    .x_o     (x_chain[0]),
    .r_o     (r_chain[0])
  );

  // Chain of refinement steps.
  for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_step
    nrr_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (v_chain[gi]),
      .x_i     (x_chain[gi]),
      .r_i     (r_chain[gi]),
      .valid_o (v_chain[gi+1]),
      .x_o     (x_chain[gi+1]),
      .r_o     (r_chain[gi+1])
    );
  end

  assign recip_valid_o = v_chain[ITERATIONS];
  assign recip_value_o = r_chain[ITERATIONS];

  // A result never exceeds 1.0 in Q1.63.
  a_recip_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    recip_valid_o |-> (recip_value_o <= nrr_pkg::ONE_Q63)
  ) else $error("reciprocal result above 1.0");

  // While the pipeline holds, the seed stage keeps its beat.
  a_seed_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    x_stall_o |=> ($stable(v_chain[0]) && $stable(r_chain[0]) && $stable(x_chain[0]))
  ) else $error("seed stage changed during a hold");

  // A held output beat is still presented in the next cycle.
  a_hold_keeps_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    x_stall_o |=> (recip_valid_o && $stable(recip_value_o))
  ) else $error("held result was lost");

endmodule : newton_raphson_reciprocal_unit

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the pipelined Newton-Raphson reciprocal unit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ITERS      = nrr_pkg::ITERATIONS_DEF;
  localparam int unsigned FBITS      = nrr_pkg::FRAC_BITS_DEF;
  localparam int unsigned LATENCY    = 1 + nrr_pkg::STEP_LAT * ITERS;
  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned N_RANDOM   = 1800;
  localparam int unsigned CYCLE_CAP  = 400000;

  // Segment edges of the divisor in its own fixed-point format.
  localparam nrr_pkg::word_t UNIT  = nrr_pkg::word_t'(1) << FBITS;
  localparam nrr_pkg::word_t TWO   = 2 * UNIT;
  localparam nrr_pkg::word_t THR33 = 3 * UNIT + (3 * UNIT + 5) / 10;
  localparam nrr_pkg::word_t FIVE  = 5 * UNIT;
  localparam nrr_pkg::word_t TEN   = 10 * UNIT;

  // Holds the reciprocals still owed by the unit and checks each result beat.
  class recip_ledger;
    nrr_pkg::word_t owed_recips[$];
    nrr_pkg::word_t owed_divisors[$];
    int unsigned    fails;
    int unsigned    checked;
    int unsigned    below_one;
    int unsigned    in_span;
    int unsigned    above_ten;

    function new();
      fails   = 0;
      checked = 0;
      below_one = 0;
      in_span   = 0;
      above_ten = 0;
    endfunction

    // floor(a*b / 2^s) saturated to one word; flags any discarded bit.
    function nrr_pkg::word_t scaled_product(nrr_pkg::word_t a, nrr_pkg::word_t b,
                                            int unsigned s, output bit inexact);
      nrr_pkg::prod_t p;
      nrr_pkg::prod_t q;
      p = nrr_pkg::prod_t'(a) * nrr_pkg::prod_t'(b);
      inexact = (p & ((nrr_pkg::prod_t'(1) << s) - 1)) != 0;
      q = p >> s;
      if (q[nrr_pkg::PROD_W-1:nrr_pkg::WORD_W] != '0) return '1;
      return q[nrr_pkg::WORD_W-1:0];
    endfunction

    // Seed from the four segments, then the truncated refinement steps.
    function nrr_pkg::word_t newton_recip(nrr_pkg::word_t x);
      nrr_pkg::word_t r;
      nrr_pkg::word_t p;
      nrr_pkg::word_t corr;
      logic [nrr_pkg::WORD_W:0] sum;
      bit inexact;
      if (x <= TWO) r = nrr_pkg::SEED_HALF;
      else if (x < THR33) r = nrr_pkg::SEED_03;
      else if (x <= FIVE) r = nrr_pkg::SEED_02;
      else r = nrr_pkg::SEED_01;
      for (int i = 0; i < ITERS; i++) begin
        p = scaled_product(r, x, FBITS, inexact);
        if (p <= nrr_pkg::ONE_Q63) begin
          corr = scaled_product(nrr_pkg::ONE_Q63 - p, r, nrr_pkg::Q63_SHIFT, inexact);
          sum = {1'b0, r} + {1'b0, corr};
          r = sum[nrr_pkg::WORD_W] ? '1 : sum[nrr_pkg::WORD_W-1:0];
        end else begin
          // A negative correction is rounded up in magnitude.
          corr = scaled_product(p - nrr_pkg::ONE_Q63, r, nrr_pkg::Q63_SHIFT, inexact);
          if (inexact && corr != '1) corr = corr + 1;
          r = (corr >= r) ? '0 : r - corr;
        end
        if (r > nrr_pkg::ONE_Q63) r = nrr_pkg::ONE_Q63;
      end
      return r;
    endfunction

    function void note_divisor(nrr_pkg::word_t x);
      if (x < UNIT) below_one++;
      else if (x < TEN) in_span++;
      else above_ten++;
      owed_divisors.push_back(x);
      owed_recips.push_back(newton_recip(x));
    endfunction

    function void check_recip(nrr_pkg::word_t got);
      nrr_pkg::word_t want;
      nrr_pkg::word_t x;
      if (owed_recips.size() == 0) begin
        $display("%0t: result beat with nothing owed: expected none, got %h", $time, got);
        fails++;
        return;
      end
      want = owed_recips.pop_front();
      x = owed_divisors.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: recip_value mismatch for x=%h: expected %h, got %h",
                 $time, x, want, got);
        fails++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           x_valid_i;
  logic           x_stall_o;
  nrr_pkg::word_t x_value_i;
  logic           recip_valid_o;
  logic           recip_stall_i;
  nrr_pkg::word_t recip_value_o;

  recip_ledger ledger = new();
  int unsigned x_beats = 0;
  int unsigned cycles  = 0;
  bit          no_idle = 1'b0;

  newton_raphson_reciprocal_unit #(
    .ITERATIONS(ITERS),
    .FRAC_BITS (FBITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .x_valid_i    (x_valid_i),
    .x_stall_o    (x_stall_o),
    .x_value_i    (x_value_i),
    .recip_valid_o(recip_valid_o),
    .recip_stall_i(recip_stall_i),
    .recip_value_o(recip_value_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: run exceeded %0d cycles with %0d results owed",
               $time, CYCLE_CAP, ledger.owed_recips.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (x_valid_i && !x_stall_o) begin
        ledger.note_divisor(x_value_i);
        x_beats++;
      end
      if (recip_valid_o && !recip_stall_i) ledger.check_recip(recip_value_o);
    end
  end

  // Random back-pressure on the result side, off during the quiet stretch.
  always @(negedge clk_i) begin
    recip_stall_i <= !no_idle && ($urandom_range(0, 99) < 10);
  end

  function automatic nrr_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Presents one divisor beat, with random idle cycles ahead of it, and holds it until taken.
  task automatic send_divisor(input nrr_pkg::word_t v);
    int unsigned seen;
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      x_valid_i <= 1'b0;
      x_value_i <= rand_word();
      @(negedge clk_i);
    end
    x_valid_i <= 1'b1;
    x_value_i <= v;
    seen = x_beats;
    do @(negedge clk_i); while (x_beats == seen);
  endtask

  // Mostly well-formed divisors, with some near segment edges and some out of range.
  function automatic nrr_pkg::word_t pick_divisor();
    int unsigned kind;
    nrr_pkg::word_t edges[5];
    kind = $urandom_range(0, 99);
    edges = '{UNIT, TWO, THR33, FIVE, TEN};
    if (kind < 70) return UNIT + (rand_word() % (TEN - UNIT));
    if (kind < 85) return edges[$urandom_range(0, 4)] + $urandom_range(0, 2000) - 1000;
    if (kind < 95) return rand_word();
    return rand_word() % UNIT;
  endfunction

  initial begin
    nrr_pkg::word_t directed[$];
    rst_ni        = 1'b0;
    x_valid_i     = 1'b0;
    x_value_i     = '0;
    recip_stall_i = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Field extremes, every seed segment edge, and divisors below one and of ten or more.
    directed = '{'0, nrr_pkg::word_t'(1), UNIT - 1, UNIT, UNIT + 1, UNIT + UNIT / 2,
                 TWO - 1, TWO, TWO + 1, THR33 - 1, THR33, THR33 + 1,
                 FIVE - 1, FIVE, FIVE + 1, 7 * UNIT + UNIT / 4, TEN - 1, TEN,
                 TEN + 1, nrr_pkg::word_t'(1) << 63, (nrr_pkg::word_t'(1) << 63) - 1,
                 '1};
    foreach (directed[i]) send_divisor(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 700 && i < 1000);
      send_divisor(pick_divisor());
    end
    no_idle = 1'b0;
    x_valid_i <= 1'b0;

    // Drain, then leave room for any stray result beat.
    while (ledger.owed_recips.size() != 0) @(negedge clk_i);
    repeat (4 * LATENCY) @(negedge clk_i);

    $display("Sent %0d divisors: %0d below one, %0d in [1,10), %0d of ten or more.",
             x_beats, ledger.below_one, ledger.in_span, ledger.above_ten);
    $display("Checked %0d reciprocals with random idle and stall on both sides.",
             ledger.checked);
    if (ledger.fails == 0 && ledger.owed_recips.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (ledger.owed_recips.size() != 0)
        $display("%0t: %0d results never arrived: expected %h for x=%h, got nothing",
                 $time, ledger.owed_recips.size(), ledger.owed_recips[0],
                 ledger.owed_divisors[0]);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/nrr_pkg.sv
rtl/nrr_mul.sv
rtl/nrr_seed.sv
rtl/nrr_step.sv
rtl/newton_raphson_reciprocal_unit.sv
verif/tb.sv
